// ----- design/mm3_pkg.sv -----
// Package for the MurmurHash3 x86_32 key hash core.
// Holds hash constants, the job word passed from front to back, and helpers.
// No dependencies.
package mm3_pkg;

    localparam logic [31:0] MM_C1          = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2          = 32'h1b873593;
    localparam logic [31:0] MM_ADD         = 32'he6546b64;
    localparam logic [31:0] MM_F1          = 32'h85ebca6b;
    localparam logic [31:0] MM_F2          = 32'hc2b2ae35;
    localparam logic [31:0] SEED_RESET     = 32'h9747b28c;

    localparam int          HASH_BITS_W    = 6;
    localparam logic [HASH_BITS_W-1:0] HASH_BITS_RESET = 6'd10;
    localparam int          HASH_BITS_MAX  = 32;

    localparam int          CFG_INDEX_W    = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_SEED = 2'd1;

    localparam int          QUEUE_DEPTH_DEF = 4;

    // One unit of work for the back end: either a full word to mix, a tail
    // word (final without full word), and/or the end of a key. A job marked
    // load_seed reloads the running hash from its seed before the mix.
    typedef struct packed {
        logic        full_word;   // run the block mix on word
        logic        final_job;   // finalize after this job
        logic [31:0] word;        // full word, or tail bytes in the low bits
        logic [31:0] count;       // key length so far, valid with final_job
        logic        load_seed;   // restart the running hash from seed
        logic [31:0] seed;        // seed latched for this key
    } job_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

    // Low-bit mask; zero for a width of zero or above 32.
    function automatic logic [31:0] hash_mask(input logic [HASH_BITS_W-1:0] n);
        logic [32:0] m;
        m = (33'd1 << n) - 33'd1;
        if (n == '0 || n > HASH_BITS_W'(HASH_BITS_MAX)) begin
            return 32'd0;
        end
        return m[31:0];
    endfunction

endpackage

// ----- design/murmur3_32_key_hash_core.sv -----
// Top level of the MurmurHash3 x86_32 key hash core.
// Holds the configuration registers and joins mm3_front, mm3_queue, mm3_back.
// Depends on mm3_pkg.
//
//  Channel   Dir  Handshake            Payload
//  s_*       in   s_tvalid/s_tready    s_tdata: data_byte[7:0]; s_tlast: last
//  m_*       out  m_tvalid/m_tready    m_tdata: hash_value[31:0]
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index: 0 hash_bits, 1 hash_seed; cfg_wdata
//
// Bytes are taken one per cycle while the job queue has room. Each full word
// passes through the back-end sequencer once (two scramble multiplies, one mix),
// so four-byte words keep pace with one byte per cycle; a key end adds two
// finalizer multiplies and the output step. With the back end idle, m_tvalid
// rises once the last byte's job has run these steps, after any queued work
// ahead of it. While a hash waits on m_tready the back end runs on to its
// output step and holds there; the front takes bytes until the job queue fills.
// Reset is synchronous on aresetn; no clearing pass is needed.
module murmur3_32_key_hash_core #(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] hash_value
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mm3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_wdata
);
    import mm3_pkg::*;

    logic [HASH_BITS_W-1:0] hash_bits_reg;
    logic [31:0]            hash_seed_reg;
    logic                   seed_wr;
    logic                   job_push;
    job_t                   push_job;
    job_t                   head_job;
    logic                   queue_full;
    logic                   queue_empty;
    logic                   job_pop;

    assign cfg_ready = 1'b1;
    assign seed_wr   = cfg_valid && cfg_ready && (cfg_index == CFG_HASH_SEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_bits_reg <= HASH_BITS_RESET;
            hash_seed_reg <= SEED_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_HASH_BITS) begin
                hash_bits_reg <= cfg_wdata[HASH_BITS_W-1:0];
            end else if (cfg_index == CFG_HASH_SEED) begin
                hash_seed_reg <= cfg_wdata;
            end
        end
    end

    mm3_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .seed       (hash_seed_reg),
        .seed_wr    (seed_wr),
        .seed_wdata (cfg_wdata),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (push_job)
    );

    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    mm3_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .head_job    (head_job),
        .pop         (job_pop),
        .hash_bits   (hash_bits_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_hash    (m_tdata)
    );

endmodule

// ----- design/mm3_front.sv -----
// Front end of the key hash core: gathers key bytes into little-endian words,
// counts bytes and queues word and end-of-key jobs. Depends on mm3_pkg.
module mm3_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic [31:0]      seed,
    input  logic             seed_wr,
    input  logic [31:0]      seed_wdata,
    input  logic             queue_full,
    output logic             job_push,
    output mm3_pkg::job_t    job
);
    import mm3_pkg::*;

    logic [23:0] partial_reg, partial_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] key_seed_reg, key_seed_next;
    logic        reload_reg, reload_next;
    logic        accept;
    logic [31:0] count_inc;
    logic [23:0] partial_ins;
    logic        idle;
    logic [31:0] seed_now;
    logic [31:0] key_seed_cur;
    logic        reload_cur;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign count_inc = count_reg + 32'd1;

    // A seed write between keys takes hold at once; mid-key it waits for the next key
    assign idle         = (count_reg == '0) && (phase_reg == '0);
    assign seed_now     = seed_wr ? seed_wdata : seed;
    assign key_seed_cur = (seed_wr && idle) ? seed_wdata : key_seed_reg;
    assign reload_cur   = (seed_wr && idle) || reload_reg;

    always_comb begin
        partial_ins = partial_reg;
        unique case (phase_reg)
            2'd0:    partial_ins[7:0]   = in_byte;
            2'd1:    partial_ins[15:8]  = in_byte;
            default: partial_ins[23:16] = in_byte;
        endcase
    end

    always_comb begin
        partial_next  = partial_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        key_seed_next = key_seed_cur;
        reload_next   = reload_cur;
        job_push      = 1'b0;
        job.full_word = (phase_reg == 2'd3);
        job.final_job = in_last;
        job.count     = count_inc;
        job.word      = (phase_reg == 2'd3) ? {in_byte, partial_reg} : {8'd0, partial_ins};
        job.load_seed = reload_cur;
        job.seed      = key_seed_cur;
        if (accept) begin
            job_push = (phase_reg == 2'd3) || in_last;
            if (job_push) begin
                reload_next = 1'b0;
            end
            if (in_last) begin
                // key done: restart gathering
                partial_next  = '0;
                phase_next    = '0;
                count_next    = '0;
                key_seed_next = seed_now;
                reload_next   = 1'b1;
            end else if (phase_reg == 2'd3) begin
                partial_next = '0;
                phase_next   = '0;
                count_next   = count_inc;
            end else begin
                partial_next = partial_ins;
                phase_next   = phase_reg + 2'd1;
                count_next   = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg  <= '0;
            phase_reg    <= '0;
            count_reg    <= '0;
            key_seed_reg <= SEED_RESET;
            reload_reg   <= 1'b1;
        end else begin
            partial_reg  <= partial_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            key_seed_reg <= key_seed_next;
            reload_reg   <= reload_next;
        end
    end

endmodule

// ----- design/mm3_queue.sv -----
// Short job queue between front and back end of the key hash core.
// Register-based FIFO of job_t entries. Depends on mm3_pkg.
module mm3_queue #(
    parameter int DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mm3_pkg::job_t    push_job,
    input  logic             pop,
    output mm3_pkg::job_t    head_job,
    output logic             full,
    output logic             empty
);
    import mm3_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full     = (cnt_reg == CntW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- design/mm3_back.sv -----
// Back end of the key hash core: block mix, tail mix and finalizer as a
// multi-cycle sequencer with one multiplier per step, plus the result register.
// Depends on mm3_pkg.
module mm3_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              queue_empty,
    input  mm3_pkg::job_t                     head_job,
    output logic                              pop,
    input  logic [mm3_pkg::HASH_BITS_W-1:0]   hash_bits,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       out_hash
);
    import mm3_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCRAMBLE2,
        S_MIX,
        S_FIN0,
        S_FIN1,
        S_OUT
    } state_t;

    state_t      state_reg;
    logic        out_valid_reg;
    logic [31:0] out_hash_reg;
    logic [31:0] h_reg;
    logic [31:0] k_reg;
    logic [31:0] count_reg;
    logic        full_word_reg;
    logic        final_reg;
    logic [31:0] mix_t;
    logic [31:0] fin0_t;
    logic [31:0] fin1_t;
    logic [31:0] fin2_t;
    logic        out_free;
    logic        out_load;

    assign pop       = (state_reg == S_IDLE) && !queue_empty;
    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_OUT) && out_free;

    assign mix_t  = h_reg ^ k_reg;
    assign fin0_t = (h_reg ^ count_reg) ^ ((h_reg ^ count_reg) >> 16);
    assign fin1_t = h_reg ^ (h_reg >> 13);
    assign fin2_t = h_reg ^ (h_reg >> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!queue_empty) begin
                        k_reg         <= head_job.word * MM_C1;
                        count_reg     <= head_job.count;
                        full_word_reg <= head_job.full_word;
                        final_reg     <= head_job.final_job;
                        // a new key starts from its latched seed
                        if (head_job.load_seed) begin
                            h_reg <= head_job.seed;
                        end
                        state_reg <= S_SCRAMBLE2;
                    end
                end
                S_SCRAMBLE2: begin
                    k_reg     <= rotl15(k_reg) * MM_C2;
                    state_reg <= S_MIX;
                end
                S_MIX: begin
                    if (full_word_reg) begin
                        h_reg <= rotl13(mix_t) * 32'd5 + MM_ADD;
                    end else begin
                        h_reg <= mix_t;
                    end
                    state_reg <= final_reg ? S_FIN0 : S_IDLE;
                end
                S_FIN0: begin
                    h_reg     <= fin0_t * MM_F1;
                    state_reg <= S_FIN1;
                end
                S_FIN1: begin
                    h_reg     <= fin1_t * MM_F2;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (out_free) begin
                        out_hash_reg <= fin2_t & hash_mask(hash_bits);
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_fin_posts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished key did not post its result");

    a_pop_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_job.load_seed) |=> (h_reg == $past(head_job.seed)))
        else $error("new key did not load seed");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_hash_reg)))
        else $error("waiting result word changed");

endmodule

// ----- verif/tb_murmur3_32_key_hash_core.sv -----
// Self-checking testbench for murmur3_32_key_hash_core: streams key bytes in,
// predicts each masked MurmurHash3 x86_32 hash and checks every result word.
// Depends on mm3_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_murmur3_32_key_hash_core;
    import mm3_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } key_byte_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'h00;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_HASH_BITS;
    logic [31:0]            cfg_wdata = 32'd0;

    murmur3_32_key_hash_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Stimulus and flow control
    key_byte_t   key_bytes_q[$];
    logic [31:0] hash_expect_q[$];
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    logic        src_pause     = 1'b0;
    logic        hold_kick     = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned err_count     = 0;

    // Predictor state
    logic [HASH_BITS_W-1:0] kept_bits = HASH_BITS_RESET;
    logic [31:0]            key_seed  = SEED_RESET;
    logic [31:0]            run_hash  = SEED_RESET;
    logic [23:0]            tail_word = 24'd0;
    logic [1:0]             tail_cnt  = 2'd0;
    logic [31:0]            key_len   = 32'd0;

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MM_C1;
        t = {t[16:0], t[31:17]};
        return t * MM_C2;
    endfunction

    function automatic logic [31:0] finish_key_hash();
        logic [31:0] h;
        h = run_hash;
        if (tail_cnt != 2'd0) h = h ^ scramble_word({8'h00, tail_word});
        h = h ^ key_len;
        h = h ^ (h >> 16);
        h = h * MM_F1;
        h = h ^ (h >> 13);
        h = h * MM_F2;
        h = h ^ (h >> 16);
        if (kept_bits == '0 || kept_bits > 6'd32) return 32'd0;
        if (kept_bits == 6'd32) return h;
        return h & ((32'd1 << kept_bits) - 32'd1);
    endfunction

    task automatic absorb_key_byte(input logic [7:0] b, input logic is_last);
        key_len = key_len + 32'd1;
        if (tail_cnt == 2'd3) begin
            run_hash = run_hash ^ scramble_word({b, tail_word});
            run_hash = {run_hash[18:0], run_hash[31:19]};
            run_hash = run_hash * 32'd5 + MM_ADD;
            tail_word = 24'd0;
            tail_cnt = 2'd0;
        end else begin
            tail_word = tail_word | (24'(b) << (8 * tail_cnt));
            tail_cnt = tail_cnt + 2'd1;
        end
        if (is_last) begin
            hash_expect_q.push_back(finish_key_hash());
            run_hash = key_seed;
            tail_word = 24'd0;
            tail_cnt = 2'd0;
            key_len = 32'd0;
        end
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        if (idx == CFG_HASH_BITS) begin
            kept_bits = val[HASH_BITS_W-1:0];
        end else if (idx == CFG_HASH_SEED) begin
            key_seed = val;
            // a seed written between keys takes hold at once
            if (key_len == 32'd0 && tail_cnt == 2'd0) run_hash = key_seed;
        end
    endtask

    task automatic note_miss(input string what, input logic [31:0] want,
                             input logic [31:0] got);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
    endtask

    // Sender: offer the next pending byte once the current byte is taken
    always @(posedge aclk) begin
        key_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) absorb_key_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (!src_pause && key_bytes_q.size() != 0 &&
                    $urandom_range(99) >= src_idle_pct) begin
                    nxt = key_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= 300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: check each hash word against the oldest prediction
    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (hash_expect_q.size() == 0) begin
                    note_miss("unexpected hash word", 32'd0, m_tdata);
                end else begin
                    want = hash_expect_q.pop_front();
                    if (m_tdata !== want) note_miss("hash_value mismatch", want, m_tdata);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic is_last);
        key_byte_t kb;
        kb.data = b;
        kb.last = is_last;
        key_bytes_q.push_back(kb);
    endtask

    task automatic push_key(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            queue_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain all queued bytes and expected hashes, then let the clock run on idle
    task automatic settle();
        while (key_bytes_q.size() != 0 || s_tvalid || hash_expect_q.size() != 0)
            @(posedge aclk);
        repeat (32) @(posedge aclk);
    endtask

    task automatic run_phase(input int unsigned n_bytes, input int unsigned src_pct,
                             input int unsigned snk_pct, input bit short_keys,
                             input bit hold_rx, input bit pause_tx);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        src_idle_pct  <= src_pct;
        snk_stall_pct <= snk_pct;
        while (sent < n_bytes) begin
            if (short_keys)
                len = $urandom_range(1, 4);
            else if ($urandom_range(9) == 0)
                len = $urandom_range(13, 48);
            else
                len = $urandom_range(1, 12);
            push_key(len);
            sent += len;
        end
        if (hold_rx) begin
            hold_kick <= 1'b1;
            @(posedge aclk);
            hold_kick <= 1'b0;
        end
        if (pause_tx) begin
            while (key_bytes_q.size() > n_bytes / 2) @(posedge aclk);
            src_pause <= 1'b1;
            @(posedge aclk);
            while (s_tvalid || hash_expect_q.size() != 0) @(posedge aclk);
            src_pause <= 1'b0;
        end
        settle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // keys of one to five bytes at reset settings
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'h01, 1'b1);
        for (int i = 1; i <= 4; i++) queue_byte(8'(i), i == 4);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h11, 1'b1);
        settle();

        // full width, zero seed loaded between keys
        write_reg(CFG_HASH_BITS, 32'd32);
        write_reg(CFG_HASH_SEED, 32'd0);
        for (int i = 0; i < 4; i++) queue_byte(8'hFF, i == 3);
        // change the seed part way through a key
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        settle();
        write_reg(CFG_HASH_SEED, 32'hFFFF_FFFF);
        queue_byte(8'h56, 1'b1);
        settle();

        // zero width and out-of-range width
        write_reg(CFG_HASH_BITS, 32'd0);
        queue_byte(8'hC3, 1'b1);
        settle();
        write_reg(CFG_HASH_BITS, 32'd63);
        queue_byte(8'h3C, 1'b1);
        settle();

        write_reg(CFG_HASH_BITS, 32'd32);
        write_reg(CFG_HASH_SEED, $urandom);
        run_phase(200, 0, 0, 1'b0, 1'b0, 1'b0);

        write_reg(CFG_HASH_BITS, 32'd1);
        write_reg(CFG_HASH_SEED, 32'd0);
        run_phase(150, 87, 0, 1'b0, 1'b0, 1'b0);

        write_reg(CFG_HASH_BITS, 32'($urandom_range(2, 31)));
        write_reg(CFG_HASH_SEED, $urandom);
        run_phase(150, 0, 87, 1'b0, 1'b0, 1'b0);

        write_reg(CFG_HASH_BITS, 32'd32);
        write_reg(CFG_HASH_SEED, 32'hFFFF_FFFF);
        run_phase(150, 13, 13, 1'b0, 1'b0, 1'b0);

        // hold the output while short keys pile up behind it
        write_reg(CFG_HASH_BITS, 32'd16);
        write_reg(CFG_HASH_SEED, $urandom);
        run_phase(100, 0, 0, 1'b1, 1'b1, 1'b0);

        write_reg(CFG_HASH_BITS, 32'($urandom_range(1, 32)));
        write_reg(CFG_HASH_SEED, $urandom);
        run_phase(150, 13, 13, 1'b0, 1'b0, 1'b1);

        while (hash_expect_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3_600_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
